/* rtl/assert_macros.svh */
// Assertion helpers shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TTF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TTF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/ttf_pkg.sv */
package ttf_pkg;

   localparam int POS_W          = 24;
   localparam int UV_W           = 16;
   localparam int OUT_W          = 16;
   localparam int UNIT_FRAC_BITS = 14;

   localparam int EDGE_W        = POS_W + 1;
   localparam int DUV_W         = UV_W + 1;
   localparam int MUL_W         = EDGE_W;
   localparam int PROD_W        = 2 * MUL_W;
   localparam int VEC_W         = PROD_W + 1;
   localparam int PRESCALE_BITS = 20;
   localparam int SQ_W          = 2 * PRESCALE_BITS;
   localparam int SUM_W         = SQ_W + 2;
   localparam int ROOT_W        = 2 * UNIT_FRAC_BITS + SUM_W + 6;
   localparam int Q_W           = UNIT_FRAC_BITS + 1;
   localparam int BIT_W         = $clog2(Q_W);
   localparam int QX_W          = (Q_W > OUT_W) ? Q_W : OUT_W;
   localparam int OUT_MAX       = 2 ** (OUT_W - 1) - 1;
   localparam int A_SHIFT       = 2 * UNIT_FRAC_BITS + 2;
   localparam int B_SHIFT       = UNIT_FRAC_BITS + 2;

   typedef enum logic [1:0] {
      VEC_NORMAL,
      VEC_TANGENT,
      VEC_BITANGENT,
      VEC_DET
   } vec_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_MUL,
      OP_ABS,
      OP_SHIFT,
      OP_SQ,
      OP_SUM,
      OP_RINIT,
      OP_ROOT,
      OP_WRITE,
      OP_LOAD_OUT
   } op_type;

   typedef struct packed {
      op_type             op;
      vec_type            vec;
      logic [1:0]         comp;
      logic               term;
      logic [BIT_W-1:0]   bitpos;
      logic [1:0]         slot;
   } cmd_type;

   typedef struct packed {
      logic big;
   } status_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [UV_W-1:0]  tex_u;
      logic signed [UV_W-1:0]  tex_v;
      logic                    last_vertex;
   } vertex_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normal_x;
      logic signed [OUT_W-1:0] normal_y;
      logic signed [OUT_W-1:0] normal_z;
      logic signed [OUT_W-1:0] tangent_x;
      logic signed [OUT_W-1:0] tangent_y;
      logic signed [OUT_W-1:0] tangent_z;
      logic signed [OUT_W-1:0] bitangent_x;
      logic signed [OUT_W-1:0] bitangent_y;
      logic signed [OUT_W-1:0] bitangent_z;
   } frame_type;

endpackage

/* rtl/ttf_vertex_if.sv */
interface ttf_vertex_if import ttf_pkg::*; ();
   logic       valid;
   logic       ready;
   vertex_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/ttf_frame_if.sv */
interface ttf_frame_if import ttf_pkg::*; ();
   logic      valid;
   logic      ready;
   frame_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/ttf_ctrl.sv */
`include "assert_macros.svh"

module ttf_ctrl import ttf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DET,
      ST_MUL,
      ST_DRAIN,
      ST_ABS,
      ST_SHIFT,
      ST_SQ,
      ST_SUM,
      ST_RINIT,
      ST_ROOT,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [1:0]       slot_ff;
   logic [2:0]       cnt_ff;
   vec_type          vec_ff;
   logic [1:0]       comp_ff;
   logic [BIT_W-1:0] bit_ff;
   logic             rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.op     = OP_NONE;
      cmd.vec    = vec_ff;
      cmd.comp   = comp_ff;
      cmd.term   = cnt_ff[0];
      cmd.bitpos = bit_ff;
      cmd.slot   = slot_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) cmd.op = OP_CAPTURE;
         ST_DET: begin
            cmd.op   = OP_MUL;
            cmd.vec  = VEC_DET;
            cmd.comp = 2'd0;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            cmd.comp = cnt_ff[2:1];
         end
         ST_DRAIN: cmd.op = OP_NONE;
         ST_ABS:   cmd.op = OP_ABS;
         ST_SHIFT: cmd.op = OP_SHIFT;
         ST_SQ: begin
            cmd.op   = OP_SQ;
            cmd.comp = cnt_ff[1:0];
         end
         ST_SUM:   cmd.op = OP_SUM;
         ST_RINIT: cmd.op = OP_RINIT;
         ST_ROOT:  cmd.op = OP_ROOT;
         ST_WRITE: cmd.op = OP_WRITE;
         ST_DONE:  if (!rsp_valid_ff || rsp_ready) cmd.op = OP_LOAD_OUT;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= 2'd0;
         cnt_ff       <= 3'd0;
         vec_ff       <= VEC_NORMAL;
         comp_ff      <= 2'd0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (slot_ff == 2'd2) begin
                     cnt_ff   <= 3'd0;
                     state_ff <= ST_DET;
                  end
                  if (req_last || slot_ff == 2'd2) slot_ff <= 2'd0;
                  else slot_ff <= slot_ff + 2'd1;
               end
            end
            ST_DET: begin
               if (cnt_ff[0]) begin
                  cnt_ff   <= 3'd0;
                  vec_ff   <= VEC_NORMAL;
                  state_ff <= ST_MUL;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            ST_MUL: begin
               if (cnt_ff == 3'd5) state_ff <= ST_DRAIN;
               else cnt_ff <= cnt_ff + 3'd1;
            end
            ST_DRAIN: state_ff <= ST_ABS;
            ST_ABS:   state_ff <= ST_SHIFT;
            ST_SHIFT: begin
               if (!status.big) begin
                  cnt_ff   <= 3'd0;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               if (cnt_ff == 3'd2) begin
                  comp_ff  <= 2'd0;
                  state_ff <= ST_SUM;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            ST_SUM:   state_ff <= ST_RINIT;
            ST_RINIT: begin
               bit_ff   <= BIT_W'(UNIT_FRAC_BITS);
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (bit_ff == '0) state_ff <= ST_WRITE;
               else bit_ff <= bit_ff - 1'b1;
            end
            ST_WRITE: begin
               if (comp_ff == 2'd2) begin
                  if (vec_ff == VEC_BITANGENT) begin
                     state_ff <= ST_DONE;
                  end else begin
                     vec_ff   <= vec_type'(vec_ff + 2'd1);
                     cnt_ff   <= 3'd0;
                     state_ff <= ST_MUL;
                  end
               end else begin
                  comp_ff  <= comp_ff + 2'd1;
                  state_ff <= ST_RINIT;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `TTF_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset")
   `TTF_ASSERT(a_load_presents, (cmd.op == OP_LOAD_OUT) |=> rsp_valid_ff, "word not presented")
   `TTF_ASSERT(a_slot_range, slot_ff != 2'd3, "vertex slot out of range")
   `TTF_ASSERT(a_root_count, (state_ff == ST_ROOT && bit_ff != '0) |=> (bit_ff == $past(bit_ff) - 1'b1), "root step")

endmodule

/* rtl/ttf_datapath.sv */
`include "assert_macros.svh"

module ttf_datapath import ttf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  vertex_type vtx,
   output status_type status,
   output frame_type  frame
);

   logic signed [POS_W-1:0]  hpos_ff [2][3];
   logic signed [UV_W-1:0]   htex_ff [2][2];
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [DUV_W-1:0]  du1_ff, dv1_ff, du2_ff, dv2_ff;

   logic signed [PROD_W-1:0] prod_ff, acc_ff;
   logic                     tag_vld_ff, tag_term_ff;
   vec_type                  tag_vec_ff;
   logic [1:0]               tag_comp_ff;

   logic signed [VEC_W-1:0]  vec_ff [3];
   logic signed [VEC_W-1:0]  det_ff;
   logic [VEC_W-1:0]         mag_ff [3];
   logic [SQ_W-1:0]          sq_ff [3];
   logic [SUM_W-1:0]         sum_ff;

   logic signed [ROOT_W-1:0] p_ff, a_ff, b_ff, r_ff;
   logic [Q_W-1:0]           q_ff;
   logic [OUT_W-1:0]         res_ff [3][3];
   frame_type                frame_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b, e1c, e2c;
   logic signed [VEC_W-1:0]  diff, vec_sel;
   logic [VEC_W-1:0]         mag_sel;
   logic [PRESCALE_BITS-1:0] msel;
   logic signed [ROOT_W-1:0] sum_x, sq_x, cand, b_acc;
   logic                     take;
   logic [QX_W-1:0]          q_x;
   logic [OUT_W-1:0]         q_sat, q_val;
   logic                     flip, neg, zero;

   // current component of each edge
   always_comb begin
      unique case (cmd.comp)
         2'd0:    begin e1c = e1_ff[0]; e2c = e2_ff[0]; end
         2'd1:    begin e1c = e1_ff[1]; e2c = e2_ff[1]; end
         2'd2:    begin e1c = e1_ff[2]; e2c = e2_ff[2]; end
         default: begin e1c = '0;       e2c = '0;       end
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.vec)
         VEC_NORMAL: begin
            unique case ({cmd.comp, cmd.term})
               3'b000:  begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
               3'b001:  begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
               3'b010:  begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
               3'b011:  begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
               3'b100:  begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
               3'b101:  begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
               default: begin mul_a = '0;       mul_b = '0;       end
            endcase
         end
         VEC_TANGENT: begin
            mul_a = cmd.term ? e2c : e1c;
            mul_b = cmd.term ? MUL_W'(dv1_ff) : MUL_W'(dv2_ff);
         end
         VEC_BITANGENT: begin
            mul_a = cmd.term ? e1c : e2c;
            mul_b = cmd.term ? MUL_W'(du2_ff) : MUL_W'(du1_ff);
         end
         VEC_DET: begin
            mul_a = cmd.term ? MUL_W'(du2_ff) : MUL_W'(du1_ff);
            mul_b = cmd.term ? MUL_W'(dv1_ff) : MUL_W'(dv2_ff);
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign diff    = VEC_W'(acc_ff) - VEC_W'(prod_ff);
   assign vec_sel = vec_ff[cmd.comp];
   assign mag_sel = mag_ff[cmd.comp];
   assign msel    = mag_sel[PRESCALE_BITS-1:0];

   assign status.big = (|mag_ff[0][VEC_W-1:PRESCALE_BITS]) |
                       (|mag_ff[1][VEC_W-1:PRESCALE_BITS]) |
                       (|mag_ff[2][VEC_W-1:PRESCALE_BITS]);

   // candidate = (2q-1)^2 * S for the trial bit, built from shifted partial terms
   assign sum_x = ROOT_W'(sum_ff);
   assign sq_x  = ROOT_W'(sq_ff[cmd.comp]);
   assign cand  = p_ff + b_ff + a_ff;
   assign take  = (cand <= r_ff) && !q_ff[Q_W-1];
   assign b_acc = take ? (b_ff + (a_ff <<< 1)) : b_ff;

   assign q_x   = QX_W'(q_ff);
   assign q_sat = (q_x > QX_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : q_x[OUT_W-1:0];
   assign flip  = (cmd.vec != VEC_NORMAL) && det_ff[VEC_W-1];
   assign neg   = vec_sel[VEC_W-1] ^ flip;
   assign zero  = (sum_ff == '0) || ((cmd.vec != VEC_NORMAL) && (det_ff == '0));
   assign q_val = zero ? '0 : (neg ? (~q_sat + 1'b1) : q_sat);

   always_ff @(posedge clock) begin
      if (reset) tag_vld_ff <= 1'b0;
      else tag_vld_ff <= (cmd.op == OP_MUL);
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE) begin
         if (cmd.slot == 2'd2) begin
            e1_ff[0] <= EDGE_W'(hpos_ff[1][0]) - EDGE_W'(hpos_ff[0][0]);
            e1_ff[1] <= EDGE_W'(hpos_ff[1][1]) - EDGE_W'(hpos_ff[0][1]);
            e1_ff[2] <= EDGE_W'(hpos_ff[1][2]) - EDGE_W'(hpos_ff[0][2]);
            e2_ff[0] <= EDGE_W'(vtx.pos_x) - EDGE_W'(hpos_ff[0][0]);
            e2_ff[1] <= EDGE_W'(vtx.pos_y) - EDGE_W'(hpos_ff[0][1]);
            e2_ff[2] <= EDGE_W'(vtx.pos_z) - EDGE_W'(hpos_ff[0][2]);
            du1_ff   <= DUV_W'(htex_ff[1][0]) - DUV_W'(htex_ff[0][0]);
            dv1_ff   <= DUV_W'(htex_ff[1][1]) - DUV_W'(htex_ff[0][1]);
            du2_ff   <= DUV_W'(vtx.tex_u) - DUV_W'(htex_ff[0][0]);
            dv2_ff   <= DUV_W'(vtx.tex_v) - DUV_W'(htex_ff[0][1]);
         end else begin
            hpos_ff[cmd.slot[0]][0] <= vtx.pos_x;
            hpos_ff[cmd.slot[0]][1] <= vtx.pos_y;
            hpos_ff[cmd.slot[0]][2] <= vtx.pos_z;
            htex_ff[cmd.slot[0]][0] <= vtx.tex_u;
            htex_ff[cmd.slot[0]][1] <= vtx.tex_v;
         end
      end

      if (cmd.op == OP_MUL) begin
         prod_ff     <= mul_a * mul_b;
         tag_vec_ff  <= cmd.vec;
         tag_comp_ff <= cmd.comp;
         tag_term_ff <= cmd.term;
      end

      if (tag_vld_ff) begin
         if (!tag_term_ff) acc_ff <= prod_ff;
         else if (tag_vec_ff == VEC_DET) det_ff <= diff;
         else vec_ff[tag_comp_ff] <= diff;
      end

      if (cmd.op == OP_ABS) begin
         for (int i = 0; i < 3; i++)
            mag_ff[i] <= vec_ff[i][VEC_W-1] ? VEC_W'(-vec_ff[i]) : VEC_W'(vec_ff[i]);
      end

      if (cmd.op == OP_SHIFT && status.big) begin
         for (int i = 0; i < 3; i++)
            mag_ff[i] <= mag_ff[i] >> 1;
      end

      if (cmd.op == OP_SQ) sq_ff[cmd.comp] <= SQ_W'(msel) * SQ_W'(msel);

      if (cmd.op == OP_SUM)
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);

      if (cmd.op == OP_RINIT) begin
         p_ff <= sum_x;
         a_ff <= sum_x <<< A_SHIFT;
         b_ff <= -(sum_x <<< B_SHIFT);
         r_ff <= sq_x <<< A_SHIFT;
         q_ff <= '0;
      end

      if (cmd.op == OP_ROOT) begin
         if (take) begin
            p_ff <= cand;
            q_ff <= q_ff | (Q_W'(1) << cmd.bitpos);
         end
         b_ff <= b_acc >>> 1;
         a_ff <= a_ff >>> 2;
      end

      if (cmd.op == OP_WRITE) res_ff[cmd.vec][cmd.comp] <= q_val;

      if (cmd.op == OP_LOAD_OUT) begin
         frame_ff.normal_x    <= res_ff[0][0];
         frame_ff.normal_y    <= res_ff[0][1];
         frame_ff.normal_z    <= res_ff[0][2];
         frame_ff.tangent_x   <= res_ff[1][0];
         frame_ff.tangent_y   <= res_ff[1][1];
         frame_ff.tangent_z   <= res_ff[1][2];
         frame_ff.bitangent_x <= res_ff[2][0];
         frame_ff.bitangent_y <= res_ff[2][1];
         frame_ff.bitangent_z <= res_ff[2][2];
      end
   end

   assign frame = frame_ff;

   `TTF_ASSERT(a_root_bound, (cmd.op == OP_ROOT) |=> (!q_ff[Q_W-1] || q_ff[Q_W-2:0] == '0), "root above unit")
   `TTF_ASSERT(a_root_scale_pos, (cmd.op == OP_ROOT) |-> !a_ff[ROOT_W-1], "root scale term negative")
   `TTF_ASSERT(a_mul_tagged, (cmd.op == OP_MUL) |=> tag_vld_ff, "product tag lost")

endmodule

/* rtl/triangle_tangent_frame_top.sv */
// The first two vertices of a triangle are only stored; the frame word of the third is
// presented once its three vectors are built, prescaled (shifted right until every
// component fits PRESCALE_BITS bits) and normalized.
// No new vertex is accepted while a triangle is in flight; the shared 15-step root search
// (three components per vector, three vectors) and the single multiplier set the pace.
// Reset (synchronous): triangle assembly restarts at the first vertex, no word pending.
module triangle_tangent_frame_top import ttf_pkg::*; (
   input logic        clock,
   input logic        reset,
   ttf_vertex_if.sink  req_chan,
   ttf_frame_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;
   frame_type  frame;
   logic       rsp_valid;
   logic       req_ready;

   ttf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.data.last_vertex),
      .req_ready (req_ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   ttf_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .vtx    (req_chan.data),
      .status (status),
      .frame  (frame)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = frame;

endmodule

/* tb/ttf_checker.sv */
`timescale 1ns / 1ps
module ttf_checker import ttf_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  vertex_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  frame_type rsp_data,
   output int   fail_count,
   output int   pending_frames
);

   localparam int PRE_BITS = 20;
   localparam int FRAC     = 14;

   // triangle assembly state
   logic signed [63:0] pos_hold [6];
   logic signed [63:0] uv_hold [4];
   int unsigned        slot;
   frame_type          frame_q [$];
   int                 mismatch_count;

   // one normalized vector: three 16-bit outputs, sign flipped when flip is set
   function automatic void unit_vector(input logic signed [63:0] v [3], input bit flip,
                                       output logic [15:0] res [3]);
      logic [63:0]  mag [3];
      logic [63:0]  mx, s2, lo, hi, mid, t, q;
      logic [127:0] lhs, rhs;
      int           sh;
      bit           neg;
      mx = 0;
      s2 = 0;
      sh = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = v[i] < 0 ? -v[i] : v[i];
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) res[i] = '0;
         return;
      end
      while ((mx >> sh) >= (64'd1 << PRE_BITS)) sh++;
      for (int i = 0; i < 3; i++) begin
         mag[i] = mag[i] >> sh;
         s2 += mag[i] * mag[i];
      end
      for (int i = 0; i < 3; i++) begin
         lo = 0;
         hi = 64'd1 << FRAC;
         if (mag[i] != 0) begin
            rhs = {64'd0, mag[i] * mag[i]} << (2 * FRAC + 2);
            while (lo < hi) begin
               mid = (lo + hi + 1) / 2;
               t = 2 * mid - 1;
               lhs = {64'd0, t * t} * {64'd0, s2};
               if (lhs <= rhs) lo = mid;
               else hi = mid - 1;
            end
         end
         q = lo > 32767 ? 32767 : lo;
         neg = (v[i] < 0) != flip;
         res[i] = neg ? 16'(-q) : 16'(q);
      end
   endfunction

   // takes one vertex; queues the frame when it completes a triangle
   task automatic take_vertex(input vertex_type vx);
      logic signed [63:0] cur [3], e1 [3], e2 [3], nv [3], tg [3], bt [3];
      logic signed [63:0] du1, dv1, du2, dv2, det;
      logic [15:0]        rn [3], rt [3], rb [3];
      frame_type          f;
      cur[0] = vx.pos_x;
      cur[1] = vx.pos_y;
      cur[2] = vx.pos_z;
      if (slot < 2) begin
         for (int i = 0; i < 3; i++) pos_hold[3 * slot + i] = cur[i];
         uv_hold[2 * slot]     = vx.tex_u;
         uv_hold[2 * slot + 1] = vx.tex_v;
         slot++;
      end else begin
         du1 = uv_hold[2] - uv_hold[0];
         dv1 = uv_hold[3] - uv_hold[1];
         du2 = 64'(vx.tex_u) - uv_hold[0];
         dv2 = 64'(vx.tex_v) - uv_hold[1];
         det = du1 * dv2 - du2 * dv1;
         for (int i = 0; i < 3; i++) begin
            e1[i] = pos_hold[3 + i] - pos_hold[i];
            e2[i] = cur[i] - pos_hold[i];
         end
         nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
         nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
         nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
         unit_vector(nv, 1'b0, rn);
         for (int i = 0; i < 3; i++) begin
            tg[i] = dv2 * e1[i] - dv1 * e2[i];
            bt[i] = du1 * e2[i] - du2 * e1[i];
         end
         if (det == 0) begin
            for (int i = 0; i < 3; i++) begin
               rt[i] = '0;
               rb[i] = '0;
            end
         end else begin
            unit_vector(tg, det < 0, rt);
            unit_vector(bt, det < 0, rb);
         end
         f = '{rn[0], rn[1], rn[2], rt[0], rt[1], rt[2], rb[0], rb[1], rb[2]};
         frame_q = {frame_q, f};
         slot = 0;
      end
      if (vx.last_vertex) slot = 0;
   endtask

   always @(posedge clock) begin
      frame_type want;
      if (reset) begin
         slot = 0;
         frame_q.delete();
         fail_count <= 0;
         pending_frames <= 0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected frame word %h", rsp_data);
               mismatch_count++;
            end else begin
               want = frame_q.pop_front();
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (mismatch_count < 10)
                     $display("frame mismatch: exp n=%0d,%0d,%0d t=%0d,%0d,%0d b=%0d,%0d,%0d",
                        want.normal_x, want.normal_y, want.normal_z,
                        want.tangent_x, want.tangent_y, want.tangent_z,
                        want.bitangent_x, want.bitangent_y, want.bitangent_z,
                        "\n   got n=%0d,%0d,%0d t=%0d,%0d,%0d b=%0d,%0d,%0d",
                        rsp_data.normal_x, rsp_data.normal_y, rsp_data.normal_z,
                        rsp_data.tangent_x, rsp_data.tangent_y, rsp_data.tangent_z,
                        rsp_data.bitangent_x, rsp_data.bitangent_y, rsp_data.bitangent_z);
                  mismatch_count++;
               end
            end
         end
         // accept after the compare so a same-edge vertex cannot be mistaken for a word
         if (req_valid && req_ready) take_vertex(req_data);
         pending_frames <= frame_q.size();
      end
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
   import ttf_pkg::*;

   localparam int TIMEOUT_CYCLES = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_frames;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   stall_phase = 0;

   ttf_vertex_if req_chan ();
   ttf_frame_if  rsp_chan ();

   triangle_tangent_frame_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   ttf_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_data       (req_chan.data),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_data       (rsp_chan.data),
      .fail_count     (fail_count),
      .pending_frames (pending_frames)
   );

   always #10 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: alternates stall-free stretches and random stall patterns
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 4000;
      if (stall_phase < 1000) rsp_chan.ready <= 1'b1;
      else if (stall_phase < 2500) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      else rsp_chan.ready <= ($urandom_range(0, 2) == 0);
   end

   function automatic logic signed [23:0] rand_pos(input int mode);
      case (mode)
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(0, 400)) - 200);
         2: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
         default: return 24'($signed($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_uv(input int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 20)) - 10);
         2: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
         default: return 16'($signed($urandom_range(0, 4095)) - 2048);
      endcase
   endfunction

   // drives one vertex word and holds it until accepted
   task automatic send_vertex(input vertex_type vx);
      if (burst_left == 0) begin
         gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
         if (gap_left != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap_left) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= vx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_tri(input vertex_type a, input vertex_type b, input vertex_type c);
      send_vertex(a);
      send_vertex(b);
      send_vertex(c);
   endtask

   // stops sending until every expected word has come back
   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
   endtask

   function automatic vertex_type mk(input int x, input int y, input int z,
                                     input int u, input int v, input bit last_v);
      return '{24'(x), 24'(y), 24'(z), 16'(u), 16'(v), last_v};
   endfunction

   function automatic vertex_type rand_vertex(input int mode, input bit last_v);
      vertex_type vx;
      vx.pos_x = rand_pos(mode);
      vx.pos_y = rand_pos(mode);
      vx.pos_z = rand_pos(mode);
      vx.tex_u = rand_uv(mode);
      vx.tex_v = rand_uv(mode);
      vx.last_vertex = last_v;
      return vx;
   endfunction

   initial begin
      vertex_type a, b, c;
      int mode;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain right triangle with a unit UV frame
      send_tri(mk(0, 0, 0, 0, 0, 0), mk(4096, 0, 0, 4096, 0, 0), mk(0, 4096, 0, 0, 4096, 0));
      // mirrored UVs: negative determinant flips tangent and bitangent
      send_tri(mk(0, 0, 0, 0, 0, 0), mk(4096, 0, 0, 0, 4096, 0), mk(0, 4096, 0, 4096, 0, 0));
      // zero determinant
      send_tri(mk(0, 0, 0, 5, 5, 0), mk(100, 7, 3, 5, 5, 0), mk(9, 200, 1, 5, 5, 0));
      // degenerate: all points equal
      send_tri(mk(77, 77, 77, 0, 0, 0), mk(77, 77, 77, 9, 0, 0), mk(77, 77, 77, 0, 9, 0));
      // position extremes
      send_tri(mk(-8388608, -8388608, -8388608, -32768, -32768, 0),
               mk(8388607, -8388608, 8388607, 32767, -32768, 0),
               mk(-8388608, 8388607, 8388607, -32768, 32767, 0));
      send_tri(mk(8388607, 8388607, 8388607, 32767, 32767, 0),
               mk(-8388608, 8388607, -8388608, 0, 32767, 0),
               mk(8388607, -8388608, 0, 32767, -1, 1));
      // incomplete triangles: last on first, then on second vertex
      send_vertex(mk(1, 2, 3, 4, 5, 1));
      send_vertex(mk(10, 2, 3, 4, 5, 0));
      send_vertex(mk(1, 20, 3, 4, 50, 1));
      send_tri(mk(0, 0, 0, 0, 0, 0), mk(0, 0, 4096, 0, 4096, 0), mk(4096, 0, 0, 4096, 0, 0));

      // wait for all frames at least once
      wait_drain();

      for (int n = 0; n < 550; n++) begin
         mode = $urandom_range(0, 3);
         if ($urandom_range(0, 19) == 0) begin
            // broken triangle
            send_vertex(rand_vertex(mode, $urandom_range(0, 1)));
            send_vertex(rand_vertex(mode, 1'b1));
         end else begin
            a = rand_vertex(mode, 1'b0);
            b = rand_vertex(mode, 1'b0);
            c = rand_vertex(mode, $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 15) == 0) b.tex_u = a.tex_u + (c.tex_u - a.tex_u);
            if ($urandom_range(0, 15) == 0) c = a;
            send_tri(a, b, c);
         end
         if (n == 275) wait_drain();
      end

      wait_drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/ttf_pkg.sv
rtl/ttf_vertex_if.sv
rtl/ttf_frame_if.sv
rtl/ttf_ctrl.sv
rtl/ttf_datapath.sv
rtl/triangle_tangent_frame_top.sv
tb/ttf_checker.sv
tb/tb.sv
